// ----- rtl/mcpp_pkg.sv -----
package mcpp_pkg;

    localparam int SLOTS_DEF       = 4;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int VAL_W           = 20;
    // Period times phase share is at most 1000000 * 99, so 27 bits hold it.
    localparam int PROD_W          = 27;
    localparam logic [VAL_W-1:0] US_PER_SEC = 20'd1000000;
    localparam logic [VAL_W-1:0] FULL_DUTY  = 20'd100;

    // Division by 100 as a multiplication by ceil(2^34 / 100) and a shift.
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;

    // Item actions.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_FREQ = 2'd1;
    localparam logic [1:0] ACT_DUTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_PH_GO,
        ST_APPLY,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clr_slot;
        logic step_slot;
        logic do_freq;
        logic do_duty_plain;
        logic tick_step;
        logic per_start;
        logic ph_start;
        logic apply_phase;
        logic duty_period;
        logic set_status;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       last_slot;
        logic       freq_hit;
        logic       duty_hit;
        logic       duty_counts;
        logic       tick_expire;
        logic       div_busy;
        logic       div_done;
        logic       out_busy;
    } t_stat;

endpackage

// ----- rtl/multi_channel_pin_pwm_unit.sv -----
// Pin PWM unit with a small table of slots, each bound to a pin by group and
// index.
// Input channel: i_valid/o_stall with action, pin group, pin index and value.
// A tick transaction advances every running slot by one microsecond; a
// frequency transaction binds, retunes or releases a slot; a duty transaction
// holds the pin or starts counting.
// Output channel: o_valid/i_stall with status, pin levels and running bits,
// one result transaction per input transaction.
// Slot walk: the slots are walked one per cycle unless a tick waits on the
// divider. A period comes from a shared one-bit-per-cycle 20-bit divider; a
// phase length is the period times the duty share, divided by 100 with a
// reciprocal multiply. The next transaction is accepted in the cycle after
// the result is loaded; one transaction is in flight at a time.
// Reset clears every slot and empties the output register.
// While the receiver stalls, the result holds and no new transaction is
// accepted once the next result is ready.
module multi_channel_pin_pwm_unit #(
    parameter int SLOTS       = mcpp_pkg::SLOTS_DEF,
    parameter int COUNT_WIDTH = mcpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_pin_group,
    input  logic [2:0]  i_pin_index,
    input  logic [19:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [3:0]  o_pin_levels,
    output logic [3:0]  o_slots_running
);
    mcpp_pkg::t_cmd  w_cmd;
    mcpp_pkg::t_stat w_stat;

    mcpp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mcpp_datapath #(.SLOTS(SLOTS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_action),
        .i_pin_group     (i_pin_group),
        .i_pin_index     (i_pin_index),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_pin_levels    (o_pin_levels),
        .o_slots_running (o_slots_running)
    );
endmodule

// ----- rtl/mcpp_div.sv -----
module mcpp_div #(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, n_quot;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_trial;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        w_trial = {r_rem, r_quot[W-1]} - {1'b0, r_den};
        n_quot  = {r_quot[W-2:0], ~w_trial[W]};
        n_rem   = w_trial[W] ? {r_rem[W-2:0], r_quot[W-1]} : w_trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- rtl/mcpp_datapath.sv -----
module mcpp_datapath #(
    parameter int SLOTS       = mcpp_pkg::SLOTS_DEF,
    parameter int COUNT_WIDTH = mcpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mcpp_pkg::t_cmd  i_cmd,
    output mcpp_pkg::t_stat o_stat,
    input  logic [1:0]      i_action,
    input  logic [3:0]      i_pin_group,
    input  logic [2:0]      i_pin_index,
    input  logic [19:0]     i_value,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_status,
    output logic [3:0]      o_pin_levels,
    output logic [3:0]      o_slots_running
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int VW = mcpp_pkg::VAL_W;
    localparam int PW = mcpp_pkg::PROD_W;
    localparam int MW = mcpp_pkg::PROD_W + mcpp_pkg::RECIP_W;
    localparam int LW = MW - mcpp_pkg::RECIP_SHIFT;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [SLOTS-1:0]      r_bound, r_running, r_phase, r_level;
    logic [3:0]            r_group  [SLOTS];
    logic [2:0]            r_pin    [SLOTS];
    logic [VW-1:0]         r_freq   [SLOTS];
    logic [VW-1:0]         r_duty   [SLOTS];
    logic [COUNT_WIDTH-1:0] r_count [SLOTS];

    logic [1:0]    r_action;
    logic [3:0]    r_g;
    logic [2:0]    r_p;
    logic [VW-1:0] r_v;
    logic [SW-1:0] r_slot;
    logic          r_status;
    logic [VW-1:0] r_period;
    logic [PW-1:0] r_prod;

    logic          r_ovalid, r_ostatus;
    logic [3:0]    r_olev, r_orun;

    logic          w_holds;
    logic [COUNT_WIDTH-1:0] w_cnt_dec;
    logic [VW-1:0] w_num, w_den, w_quot;
    logic          w_div_start, w_div_busy, w_div_done;
    logic [MW-1:0] w_recip;
    logic [LW-1:0] w_ph_len;
    logic [COUNT_WIDTH-1:0] w_per_cnt, w_ph_cnt;
    logic [SLOTS-1:0] w_lv_ext, w_rn_ext;

    // Slot being examined.
    assign w_holds   = r_bound[r_slot] && r_group[r_slot] == r_g && r_pin[r_slot] == r_p;
    assign w_cnt_dec = (r_count[r_slot] != '0) ? r_count[r_slot] - 1'b1 : '0;

    // The divider only forms the period of the current slot.
    assign w_num       = mcpp_pkg::US_PER_SEC;
    assign w_den       = r_freq[r_slot];
    assign w_div_start = i_cmd.per_start;

    mcpp_div #(.W(VW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Phase length: the registered product divided by 100 through a reciprocal.
    assign w_recip  = MW'(r_prod) * MW'(mcpp_pkg::RECIP_100);
    assign w_ph_len = w_recip[MW-1:mcpp_pkg::RECIP_SHIFT];

    // Counts that do not fit saturate to the largest count.
    assign w_per_cnt = (64'(w_quot) > 64'(CMAX)) ? CMAX : COUNT_WIDTH'(w_quot);
    assign w_ph_cnt  = (64'(w_ph_len) > 64'(CMAX)) ? CMAX : COUNT_WIDTH'(w_ph_len);

    // Item capture, slot walk, and slot updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound   <= '0;
            r_running <= '0;
            r_phase   <= '0;
            r_level   <= '0;
            r_slot    <= '0;
            r_status  <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_group[s] <= '0;
                r_pin[s]   <= '0;
                r_freq[s]  <= '0;
                r_duty[s]  <= '0;
                r_count[s] <= '0;
            end
        end else begin
            if (i_cmd.load_item) begin
                r_action <= i_action;
                r_g      <= i_pin_group;
                r_p      <= i_pin_index;
                r_v      <= i_value;
                r_status <= 1'b0;
            end
            if (i_cmd.clr_slot) begin
                r_slot <= '0;
            end
            if (i_cmd.step_slot) begin
                r_slot <= r_slot + 1'b1;
            end
            if (i_cmd.set_status) begin
                r_status <= 1'b1;
            end
            // Frequency item: bind, retune or release the current slot.
            if (i_cmd.do_freq) begin
                if (r_v == '0) begin
                    r_bound[r_slot]   <= 1'b0;
                    r_running[r_slot] <= 1'b0;
                    r_level[r_slot]   <= 1'b0;
                    r_phase[r_slot]   <= 1'b0;
                    r_count[r_slot]   <= '0;
                end else if (!r_bound[r_slot]) begin
                    r_bound[r_slot]   <= 1'b1;
                    r_group[r_slot]   <= r_g;
                    r_pin[r_slot]     <= r_p;
                    r_freq[r_slot]    <= r_v;
                    r_duty[r_slot]    <= '0;
                    r_running[r_slot] <= 1'b0;
                    r_phase[r_slot]   <= 1'b0;
                    r_count[r_slot]   <= '0;
                    r_level[r_slot]   <= 1'b0;
                end else begin
                    r_freq[r_slot] <= r_v;
                end
            end
            // Duty item that holds the pin or starts counting.
            if (i_cmd.do_duty_plain) begin
                r_running[r_slot] <= 1'b0;
                r_phase[r_slot]   <= 1'b0;
                r_count[r_slot]   <= '0;
                r_duty[r_slot]    <= r_v;
                r_level[r_slot]   <= (r_v >= mcpp_pkg::FULL_DUTY);
            end
            if (i_cmd.duty_period) begin
                r_count[r_slot]   <= w_per_cnt;
                r_running[r_slot] <= (w_per_cnt != '0);
            end
            // Tick on one slot; an expiry flips the phase.
            if (i_cmd.tick_step && r_running[r_slot]) begin
                r_count[r_slot] <= w_cnt_dec;
                if (w_cnt_dec == '0) begin
                    r_level[r_slot] <= ~r_phase[r_slot];
                    r_phase[r_slot] <= ~r_phase[r_slot];
                end
            end
            // Keep the period once the divider is done.
            if (w_div_done) begin
                r_period <= w_quot;
            end
            if (i_cmd.apply_phase) begin
                r_count[r_slot] <= w_ph_cnt;
                if (w_ph_cnt == '0) begin
                    r_running[r_slot] <= 1'b0;
                end
            end
        end
    end

    // Product of period and phase share, registered before the division by 100.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ph_start) begin
            if (r_phase[r_slot]) begin
                r_prod <= PW'(r_period) * PW'(r_duty[r_slot]);
            end else begin
                r_prod <= PW'(r_period) * PW'(mcpp_pkg::FULL_DUTY - r_duty[r_slot]);
            end
        end
    end

    // Output register.
    always_comb begin
        w_lv_ext = r_level;
        w_rn_ext = r_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid  <= 1'b1;
            r_ostatus <= r_status;
            for (int b = 0; b < 4; b++) begin
                r_olev[b] <= (b < SLOTS) ? w_lv_ext[b % SLOTS] : 1'b0;
                r_orun[b] <= (b < SLOTS) ? w_rn_ext[b % SLOTS] : 1'b0;
            end
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_pin_levels    = r_olev;
    assign o_slots_running = r_orun;

    // A release only takes a bound slot holding the pin; a bind also takes a free one.
    always_comb begin
        o_stat.action      = r_action;
        o_stat.last_slot   = (r_slot == SW'(SLOTS - 1));
        o_stat.freq_hit    = (r_v == '0) ? w_holds : (!r_bound[r_slot] || w_holds);
        o_stat.duty_hit    = w_holds;
        o_stat.duty_counts = (r_v != '0) && (r_v < mcpp_pkg::FULL_DUTY);
        o_stat.tick_expire = r_running[r_slot] && (w_cnt_dec == '0);
        o_stat.div_busy    = w_div_busy;
        o_stat.div_done    = w_div_done;
        o_stat.out_busy    = r_ovalid && i_stall;
    end

`ifndef SYNTHESIS
    a_running_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_running[r_slot] && r_count[r_slot] == '0))
        else $error("running slot with zero count");
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_freq && r_v == '0) |=> !r_bound[$past(r_slot)] && !r_running[$past(r_slot)])
        else $error("release left slot active");
    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider restarted while busy");
`endif
endmodule

// ----- rtl/mcpp_ctrl.sv -----
module mcpp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mcpp_pkg::t_stat i_stat,
    output mcpp_pkg::t_cmd  o_cmd
);
    mcpp_pkg::t_state r_state, n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcpp_pkg::ST_IDLE: begin
                if (i_valid) n_state = mcpp_pkg::ST_SCAN;
            end
            mcpp_pkg::ST_SCAN: begin
                case (i_stat.action)
                    mcpp_pkg::ACT_TICK: begin
                        if (i_stat.tick_expire) n_state = mcpp_pkg::ST_PER_GO;
                        else if (i_stat.last_slot) n_state = mcpp_pkg::ST_OUT;
                    end
                    mcpp_pkg::ACT_FREQ: begin
                        if (i_stat.freq_hit || i_stat.last_slot) n_state = mcpp_pkg::ST_OUT;
                    end
                    mcpp_pkg::ACT_DUTY: begin
                        if (i_stat.duty_hit && i_stat.duty_counts)
                            n_state = mcpp_pkg::ST_DUTY_GO;
                        else if (i_stat.duty_hit || i_stat.last_slot)
                            n_state = mcpp_pkg::ST_OUT;
                    end
                    default: n_state = mcpp_pkg::ST_OUT;
                endcase
            end
            mcpp_pkg::ST_PER_GO:   n_state = mcpp_pkg::ST_PER_WAIT;
            mcpp_pkg::ST_PER_WAIT: begin
                if (i_stat.div_done) n_state = mcpp_pkg::ST_PH_GO;
            end
            mcpp_pkg::ST_PH_GO:    n_state = mcpp_pkg::ST_APPLY;
            mcpp_pkg::ST_APPLY: begin
                n_state = i_stat.last_slot ? mcpp_pkg::ST_OUT : mcpp_pkg::ST_SCAN;
            end
            mcpp_pkg::ST_DUTY_GO:  n_state = mcpp_pkg::ST_DUTY_WAIT;
            mcpp_pkg::ST_DUTY_WAIT: begin
                if (i_stat.div_done) n_state = mcpp_pkg::ST_OUT;
            end
            mcpp_pkg::ST_OUT: begin
                if (!i_stat.out_busy) n_state = mcpp_pkg::ST_IDLE;
            end
            default: n_state = mcpp_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            mcpp_pkg::ST_IDLE: begin
                o_stall         = 1'b0;
                o_cmd.load_item = i_valid;
                o_cmd.clr_slot  = i_valid;
            end
            mcpp_pkg::ST_SCAN: begin
                case (i_stat.action)
                    mcpp_pkg::ACT_TICK: begin
                        o_cmd.tick_step = 1'b1;
                        o_cmd.step_slot = !i_stat.tick_expire && !i_stat.last_slot;
                    end
                    mcpp_pkg::ACT_FREQ: begin
                        o_cmd.do_freq    = i_stat.freq_hit;
                        o_cmd.step_slot  = !i_stat.freq_hit && !i_stat.last_slot;
                        o_cmd.set_status = !i_stat.freq_hit && i_stat.last_slot;
                    end
                    mcpp_pkg::ACT_DUTY: begin
                        o_cmd.do_duty_plain = i_stat.duty_hit;
                        o_cmd.step_slot     = !i_stat.duty_hit && !i_stat.last_slot;
                        o_cmd.set_status    = !i_stat.duty_hit && i_stat.last_slot;
                    end
                    default: ;
                endcase
            end
            mcpp_pkg::ST_PER_GO:  o_cmd.per_start = 1'b1;
            mcpp_pkg::ST_PH_GO:   o_cmd.ph_start  = 1'b1;
            mcpp_pkg::ST_APPLY: begin
                o_cmd.apply_phase = 1'b1;
                o_cmd.step_slot   = !i_stat.last_slot;
            end
            mcpp_pkg::ST_DUTY_GO: o_cmd.per_start = 1'b1;
            mcpp_pkg::ST_DUTY_WAIT: o_cmd.duty_period = i_stat.div_done;
            mcpp_pkg::ST_OUT: o_cmd.out_load = !i_stat.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mcpp_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_state == mcpp_pkg::ST_SCAN)
        else $error("accept did not start scan");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcpp_pkg::ST_PER_WAIT || r_state == mcpp_pkg::ST_DUTY_WAIT)
        |-> (i_stat.div_busy || i_stat.div_done))
        else $error("waiting with divider idle");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == mcpp_pkg::ST_IDLE)
        else $error("output load not followed by idle");
`endif
endmodule
